// ----- hdl/hpi_pkg.sv -----
// ============================================================================
// hpi_pkg
// Shared types, constants and constant-path helpers for the hexagonal
// position to pixel index core.
// ============================================================================
package hpi_pkg;

  // fixed-point layout: lengths in 2^-(FRAC_BITS+16) micrometre
  localparam int FRAC_BITS  = 4;
  localparam int INDEX_BITS = 10;
  localparam int GBITS      = FRAC_BITS + 16;
  localparam int POS_W      = 37 + FRAC_BITS;   // shifted position, signed
  localparam int DVW        = 24 + FRAC_BITS;   // divisor and remainder width
  localparam int QW         = 21;               // quotient magnitude bits
  localparam int IW         = QW + 3;           // signed row and column width
  localparam int CW         = DVW + 22;         // slope compare width, signed
  localparam int IDX_LIM    = 1 << INDEX_BITS;

  // sqrt(3) scaled by 2^16 and its derived factors
  localparam logic [16:0] SQ3          = 17'd113512;
  localparam logic signed [17:0] SQ3S  = 18'sd113512;
  localparam logic [15:0] SQ3_HALF     = 16'd56756;
  localparam logic [14:0] SQ3_QUARTER  = 15'd28378;
  localparam logic [15:0] LW_COEF      = 16'd37837;   // (SQ3 - 1) / 3
  localparam logic [16:0] DIV3_RECIP   = 17'd43691;   // 2^17 / 3 rounded up
  localparam int X_SHIFT_UM = 7;
  localparam int Y_SHIFT_UM = 25;

  // register reset values
  localparam logic [7:0]  PITCH_RST   = 8'd50;
  localparam logic [9:0]  ROW_MIN_RST = 10'd1;
  localparam logic [10:0] ROW_MAX_RST = 11'd138;
  localparam logic [9:0]  COL_MIN_RST = 10'd1;
  localparam logic [10:0] COL_MAX_RST = 11'd160;

  typedef enum logic [2:0] {
    CFG_PITCH   = 3'd0,
    CFG_ROW_MIN = 3'd1,
    CFG_ROW_MAX = 3'd2,
    CFG_COL_MIN = 3'd3,
    CFG_COL_MAX = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [19:0] x_pos;
    logic signed [19:0] y_pos;
  } hpi_in_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic                  in_range;
  } hpi_out_t;

  typedef struct packed {
    logic [9:0]  row_min;
    logic [10:0] row_max;
    logic [9:0]  col_min;
    logic [10:0] col_max;
  } bnd_t;

  // first level of derived constants (products)
  typedef struct packed {
    logic [7:0]     p;
    logic [23:0]    pxm;
    logic [18:0]    cxp;
    logic [DVW-1:0] lw;
    logic [18:0]    yrp;
  } l1_t;

  // second level of derived constants, used by the datapath
  typedef struct packed {
    logic [DVW-1:0]          px;
    logic [DVW-1:0]          pint;
    logic [DVW-1:0]          phalf;
    logic [DVW-1:0]          lw;
    logic [DVW-1:0]          l2;
    logic signed [POS_W-1:0] xadj;
    logic signed [POS_W-1:0] yadj;
  } l2_t;

  function automatic l1_t calc_l1(input logic [7:0] pitch, input logic [10:0] rmax,
                                  input logic [10:0] cmax);
    logic [7:0]  p;
    logic [15:0] pf;
    logic [31:0] pf_div;
    l1_t         r;
    p      = (pitch == 8'd0) ? 8'd1 : pitch;
    pf     = 16'(p) << FRAC_BITS;
    pf_div = 32'(pf) * 32'(DIV3_RECIP);
    r.p    = p;
    r.pxm  = 24'(p) * 24'(SQ3_HALF);
    r.cxp  = 19'(12'(cmax) + 12'd3) * 19'(p);
    // floor(p * SQ3 * 2^F / 3) split as p*37837*2^F + floor(p*2^F / 3)
    r.lw   = (DVW'(24'(p) * 24'(LW_COEF)) << FRAC_BITS) + DVW'(pf_div >> 17);
    r.yrp  = 19'(12'(rmax) + 12'd2) * 19'(p);
    return r;
  endfunction

  function automatic l2_t calc_l2(input l1_t a);
    logic [POS_W-1:0] xo;
    l2_t              r;
    xo      = (POS_W'(a.cxp) * POS_W'(SQ3_QUARTER)) << FRAC_BITS;
    r.px    = DVW'(a.pxm) << FRAC_BITS;
    r.pint  = DVW'(a.p) << GBITS;
    r.phalf = DVW'(a.p) << (GBITS - 1);
    r.lw    = a.lw;
    r.l2    = a.lw >> 1;
    r.xadj  = $signed(xo - POS_W'(a.lw) + (POS_W'(X_SHIFT_UM) << GBITS));
    r.yadj  = $signed((POS_W'(a.yrp) << (GBITS - 1)) + (POS_W'(Y_SHIFT_UM) << GBITS));
    return r;
  endfunction

endpackage

// ----- hdl/hpi_div.sv -----
// ============================================================================
// hpi_div
// Pipelined floor divider: one restoring quotient bit per stage, returns the
// floor quotient and the non-negative remainder.
// ============================================================================
module hpi_div #(
  parameter int PW = hpi_pkg::POS_W,
  parameter int DW = hpi_pkg::DVW,
  parameter int QB = hpi_pkg::QW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic signed [PW-1:0] a_i,
  input  logic [DW-1:0]        b_i,
  output logic                 vld_o,
  output logic signed [QB:0]   q_o,
  output logic [DW-1:0]        r_o
);
  import hpi_pkg::*;

  logic [QB:0]   vld_q;
  logic [QB:0]   neg_q;
  logic [DW-1:0] rem_q [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [PW-1:0] mag;
  logic [DW:0]   trial [QB];
  logic          ge    [QB];
  logic [DW-1:0] nrem  [QB];

  // negative dividends are divided as -a-1, then mirrored at the end
  assign mag = a_i[PW-1] ? ~a_i : a_i;

  // one trial subtraction per stage
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_q[k], lo_q[k][QB-1]};
      ge[k]    = trial[k] >= {1'b0, b_i};
      nrem[k]  = ge[k] ? DW'(trial[k] - {1'b0, b_i}) : DW'(trial[k]);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else begin
      vld_q <= {vld_q[QB-1:0], vld_i};
      vld_o <= vld_q[QB];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    rem_q[0] <= DW'(mag[PW-2:QB]);
    lo_q[0]  <= mag[QB-1:0];
    quo_q[0] <= '0;
    neg_q[0] <= a_i[PW-1];
    for (int k = 0; k < QB; k++) begin
      rem_q[k+1] <= nrem[k];
      lo_q[k+1]  <= lo_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][QB-2:0], ge[k]};
      neg_q[k+1] <= neg_q[k];
    end
    q_o <= neg_q[QB] ? $signed(~{1'b0, quo_q[QB]}) : $signed({1'b0, quo_q[QB]});
    r_o <= neg_q[QB] ? (b_i - DW'(1) - rem_q[QB]) : rem_q[QB];
  end

endmodule

// ----- hdl/hpi_cfg.sv -----
// ============================================================================
// hpi_cfg
// Configuration registers and the two-level registered constant path that
// derives pitch-dependent lengths and origin offsets.
// ============================================================================
module hpi_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [10:0]   cfg_wdata_i,
  output hpi_pkg::bnd_t bnd_o,
  output hpi_pkg::l2_t  k_o
);
  import hpi_pkg::*;

  logic [7:0] pitch_q;
  bnd_t       bnd_q;
  l1_t        l1_q;
  l2_t        l2_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q       <= PITCH_RST;
      bnd_q.row_min <= ROW_MIN_RST;
      bnd_q.row_max <= ROW_MAX_RST;
      bnd_q.col_min <= COL_MIN_RST;
      bnd_q.col_max <= COL_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PITCH:   pitch_q       <= cfg_wdata_i[7:0];
        CFG_ROW_MIN: bnd_q.row_min <= cfg_wdata_i[9:0];
        CFG_ROW_MAX: bnd_q.row_max <= cfg_wdata_i;
        CFG_COL_MIN: bnd_q.col_min <= cfg_wdata_i[9:0];
        CFG_COL_MAX: bnd_q.col_max <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // derived constants, registered through l1_q and then l2_q after a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= calc_l1(PITCH_RST, ROW_MAX_RST, COL_MAX_RST);
      l2_q <= calc_l2(calc_l1(PITCH_RST, ROW_MAX_RST, COL_MAX_RST));
    end else begin
      l1_q <= calc_l1(pitch_q, bnd_q.row_max, bnd_q.col_max);
      l2_q <= calc_l2(l1_q);
    end
  end

  assign bnd_o = bnd_q;
  assign k_o   = l2_q;

endmodule

// ----- hdl/hex_position_to_pixel_index_core.sv -----
// ============================================================================
// hex_position_to_pixel_index_core
// Maps a signed hit position to a hexagonal pixel row and column.
// ============================================================================
// Pipeline: input and offset stages, the divider input register, 21 divider
// stages, divider output and two resolve stages; the pipeline depth follows
// from one quotient bit per stage.
// Throughput: one transaction per cycle, busy never rises.
// Reset: clears valid bits and loads the register reset values; derived
// constants follow a register write through l1_q and then l2_q in hpi_cfg.
module hex_position_to_pixel_index_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hpi_pkg::hpi_in_t  in_i,
  output logic              res_valid_o,
  output hpi_pkg::hpi_out_t res_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [10:0]       cfg_wdata_i
);
  import hpi_pkg::*;

  localparam int LAT_PAST = QW + 6;

  bnd_t    bnd;
  l2_t     k;
  logic    s0_vld_q, s1_vld_q, sa_vld_q, out_vld_q;
  hpi_in_t s0_in_q;
  logic signed [POS_W-1:0] s1_x_q, s1_y_q;
  logic                    dx_vld, dy_vld;
  logic signed [QW:0]      qx, qy;
  logic [DVW-1:0]          xx, my;

  logic signed [IW-1:0] j_c, colb_c, rowa_c, rowb_c, fq_c;
  logic                 ge_half_c;
  logic [DVW-1:0]       fm_c;
  logic signed [DVW:0]  dx2_c, dx1_c;

  logic signed [IW-1:0] sa_j_q, sa_colb_q, sa_rowa_q, sa_rowb_q;
  logic [DVW-1:0]       sa_ysub_q, sa_ys_q;
  logic                 sa_even_q, sa_odd_q, sa_le_l2_q, sa_ge_lw_q;
  logic signed [CW-1:0] sa_s2_q, sa_s1_q;

  logic signed [CW-1:0] pint16, ysub16, ys16, lim2, lim1;
  logic                 sub_hi, ys_hi, brow, bcol, ok;
  logic signed [IW-1:0] r_c, c_c;
  hpi_out_t             out_q;

  assign busy = 1'b0;

  // configuration and derived constants
  hpi_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .bnd_o (bnd),
    .k_o   (k)
  );

  // input capture and origin shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_in_q <= in_i;
    s1_x_q  <= (POS_W'(s0_in_q.x_pos) <<< 16) + k.xadj;
    s1_y_q  <= (POS_W'(s0_in_q.y_pos) <<< 16) + k.yadj;
  end

  // column strip and row band division
  hpi_div #(.PW(POS_W), .DW(DVW), .QB(QW)) u_div_x (
    .clk_i, .rst_ni, .vld_i(s1_vld_q), .a_i(s1_x_q), .b_i(k.px),
    .vld_o(dx_vld), .q_o(qx), .r_o(xx)
  );

  hpi_div #(.PW(POS_W), .DW(DVW), .QB(QW)) u_div_y (
    .clk_i, .rst_ni, .vld_i(s1_vld_q), .a_i(s1_y_q), .b_i(k.pint),
    .vld_o(dy_vld), .q_o(qy), .r_o(my)
  );

  // truncated candidates and half-row shifted remainder
  always_comb begin
    j_c       = IW'(qx) + ((qx[QW] && (xx != '0)) ? IW'(1) : IW'(0));
    colb_c    = IW'(qx) + IW'(1)
              + ((qx[QW] && (qx != '1) && (xx != '0)) ? IW'(1) : IW'(0));
    rowa_c    = IW'(qy) + ((qy[QW] && (my != '0)) ? IW'(1) : IW'(0));
    ge_half_c = my >= k.phalf;
    fq_c      = ge_half_c ? IW'(qy) : IW'(qy) - IW'(1);
    fm_c      = ge_half_c ? (my - k.phalf) : (my + (k.pint - k.phalf));
    rowb_c    = fq_c + ((fq_c[IW-1] && (fm_c != '0)) ? IW'(1) : IW'(0));
    dx2_c     = $signed({1'b0, xx}) - $signed({1'b0, k.l2});
    dx1_c     = $signed({1'b0, xx}) - $signed({1'b0, k.lw});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else begin
      sa_vld_q <= dx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_j_q     <= j_c;
    sa_colb_q  <= colb_c;
    sa_rowa_q  <= rowa_c;
    sa_rowb_q  <= rowb_c;
    sa_ysub_q  <= fm_c;
    sa_ys_q    <= my;
    sa_even_q  <= !j_c[0];
    sa_odd_q   <= j_c[0] && !j_c[IW-1];
    sa_le_l2_q <= xx <= k.l2;
    sa_ge_lw_q <= xx >= k.lw;
    sa_s2_q    <= CW'(SQ3S) * CW'(dx2_c);
    sa_s1_q    <= CW'(SQ3S) * CW'(dx1_c);
  end

  // slanted edge rules and bound check
  always_comb begin
    pint16 = $signed(CW'(k.pint) << 16);
    ysub16 = $signed(CW'(sa_ysub_q) << 16);
    ys16   = $signed(CW'(sa_ys_q) << 16);
    lim2   = pint16 - sa_s2_q;
    lim1   = pint16 - sa_s1_q;
    sub_hi = sa_ysub_q >= k.phalf;
    ys_hi  = sa_ys_q >= k.phalf;
    if (sa_le_l2_q && sa_even_q) begin
      brow = 1'b1; bcol = 1'b0;
    end else if (sa_le_l2_q && sa_odd_q) begin
      brow = 1'b0; bcol = 1'b0;
    end else if (sa_ge_lw_q && sa_even_q) begin
      brow = 1'b0; bcol = 1'b1;
    end else if (sa_ge_lw_q && sa_odd_q) begin
      brow = 1'b1; bcol = 1'b1;
    end else if (sa_even_q) begin
      if (sub_hi) begin
        brow = ysub16 < lim2;
        bcol = !(ysub16 < lim2);
      end else begin
        brow = !(ysub16 <= sa_s2_q);
        bcol = ysub16 <= sa_s2_q;
      end
    end else if (sa_odd_q && ys_hi) begin
      brow = !(ys16 <= lim1);
      bcol = !(ys16 <= lim1);
    end else begin
      brow = ys16 <= sa_s1_q;
      bcol = ys16 <= sa_s1_q;
    end
    r_c = brow ? sa_rowb_q : sa_rowa_q;
    c_c = bcol ? sa_colb_q : sa_j_q;
    ok  = (r_c >= $signed(IW'(bnd.row_min))) && (r_c < $signed(IW'(bnd.row_max)))
       && (r_c < $signed(IW'(IDX_LIM)))
       && (c_c >= $signed(IW'(bnd.col_min))) && (c_c < $signed(IW'(bnd.col_max)))
       && (c_c < $signed(IW'(IDX_LIM)));
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.row      <= ok ? r_c[INDEX_BITS-1:0] : '0;
    out_q.col      <= ok ? c_c[INDEX_BITS-1:0] : '0;
    out_q.in_range <= ok;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // both division pipelines stay in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_vld == dy_vld)
    else $error("x and y divider valid bits differ");

  // every result traces back to one accepted transaction
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LAT_PAST))
    else $error("result without matching transaction");

  // rejected positions report a zero index pair
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.in_range) |-> (res_o.row == '0 && res_o.col == '0))
    else $error("out of range result carries nonzero index");

endmodule
